>>> design/msc_pkg.sv
`timescale 1ns / 1ps

package msc_pkg;

    localparam int MAX_PATTERN_DEF = 32;
    localparam int MAX_BUFFER_DEF  = 1048576;

    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int PAT_BYTES   = 32;
    localparam int PAT_W       = PAT_BYTES * 8;
    localparam int CARE_W      = 32;
    localparam int LEN_REG_W   = 6;
    localparam int LEN_W       = 7;
    localparam int OFFSET_W    = 20;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT0 = 3'd0,
        CFG_PAT1 = 3'd1,
        CFG_PAT2 = 3'd2,
        CFG_PAT3 = 3'd3,
        CFG_CARE = 3'd4,
        CFG_LEN  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic                match_found;
        logic [OFFSET_W-1:0] match_offset;
        logic                buffer_done;
    } t_out_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage

>>> design/masked_byte_pattern_scanner.sv
`timescale 1ns / 1ps

// Masked byte pattern scanner: takes one buffer byte per cycle unless full and
// reports the first offset where the configured pattern (up to 32 bytes, care
// mask bit set means exact byte, clear means wildcard) matches, or a not-found
// result on the buffer's last byte. The whole window is compared in parallel
// in the cycle a byte is accepted, so one byte is taken every cycle while full
// is low. A result goes into a two-entry result queue, then the output
// register; the two absorb stalls on the result side, and full rises only once
// three results are waiting. Write configuration between buffers only.
module masked_byte_pattern_scanner #(
    parameter int MAX_PATTERN = msc_pkg::MAX_PATTERN_DEF,
    parameter int MAX_BUFFER  = msc_pkg::MAX_BUFFER_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [msc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [msc_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                             push,
    output logic                             full,
    input  msc_pkg::t_in_item                i_item,
    input  logic                             pop,
    output logic                             empty,
    output msc_pkg::t_out_item               o_item
);

    localparam int RES_W = $bits(msc_pkg::t_out_item);

    logic                accept;
    logic                emit;
    msc_pkg::t_out_item  result;
    logic                q_wr;
    logic                q_rd;
    logic [RES_W-1:0]    q_rdata;
    msc_pkg::t_fifo_stat q_stat;

    assign full   = q_stat.full;
    assign accept = push && !full;
    assign q_wr   = accept && emit;

    msc_front #(
        .MAX_PATTERN (MAX_PATTERN),
        .MAX_BUFFER  (MAX_BUFFER)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_item     (i_item),
        .o_emit     (emit),
        .o_result   (result)
    );

    msc_fifo #(
        .WIDTH (RES_W),
        .DEPTH (msc_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_wdata (result),
        .i_rd    (q_rd),
        .o_rdata (q_rdata),
        .o_stat  (q_stat)
    );

    msc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_q_data (q_rdata),
        .o_q_rd   (q_rd),
        .pop      (pop),
        .empty    (empty),
        .o_item   (o_item)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_wr && q_stat.full))
        else $error("result queue written while full");

    a_notfound_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_item.match_found) |->
            (o_item.buffer_done && (o_item.match_offset == '0)))
        else $error("not-found result without buffer end or with offset");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result visible right after reset");

    a_write_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_wr |=> !q_stat.empty)
        else $error("queued result lost");

endmodule

>>> design/msc_fifo.sv
`timescale 1ns / 1ps

module msc_fifo #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 2
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_wr,
    input  logic [WIDTH-1:0]       i_wdata,
    input  logic                   i_rd,
    output logic [WIDTH-1:0]       o_rdata,
    output msc_pkg::t_fifo_stat    o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (i_wr) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_rd) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_wr && !i_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_wr && i_rd) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    assign o_rdata      = r_mem[r_rptr];
    assign o_stat.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule

>>> design/msc_front.sv
`timescale 1ns / 1ps

module msc_front #(
    parameter int MAX_PATTERN = msc_pkg::MAX_PATTERN_DEF,
    parameter int MAX_BUFFER  = msc_pkg::MAX_BUFFER_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [msc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [msc_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                             i_accept,
    input  msc_pkg::t_in_item                i_item,
    output logic                             o_emit,
    output msc_pkg::t_out_item               o_result
);

    localparam int SEEN_W = $clog2(MAX_BUFFER + 1);
    localparam int DIFF_W = (SEEN_W > msc_pkg::OFFSET_W) ? SEEN_W : msc_pkg::OFFSET_W;
    localparam int LEN_W  = msc_pkg::LEN_W;

    logic [msc_pkg::PAT_W-1:0]     r_pat;
    logic [msc_pkg::CARE_W-1:0]    r_care;
    logic [msc_pkg::LEN_REG_W-1:0] r_len;

    logic [7:0]        r_win [MAX_PATTERN];
    logic [7:0]        n_win [MAX_PATTERN];
    logic [SEEN_W-1:0] r_seen, n_seen;
    logic              r_latched, n_latched;

    logic [LEN_W-1:0]  eff_len;
    logic [SEEN_W-1:0] seen_inc;
    logic              enough;
    logic              window_ok;
    logic              found;
    logic [DIFF_W-1:0] diff;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat  <= '0;
            r_care <= '0;
            r_len  <= msc_pkg::LEN_REG_W'(1);
        end else if (i_cfg_we) begin
            case (msc_pkg::t_cfg_idx'(i_cfg_idx))
                msc_pkg::CFG_PAT0: r_pat[0*msc_pkg::CFG_W +: msc_pkg::CFG_W] <= i_cfg_data;
                msc_pkg::CFG_PAT1: r_pat[1*msc_pkg::CFG_W +: msc_pkg::CFG_W] <= i_cfg_data;
                msc_pkg::CFG_PAT2: r_pat[2*msc_pkg::CFG_W +: msc_pkg::CFG_W] <= i_cfg_data;
                msc_pkg::CFG_PAT3: r_pat[3*msc_pkg::CFG_W +: msc_pkg::CFG_W] <= i_cfg_data;
                msc_pkg::CFG_CARE: r_care <= i_cfg_data[msc_pkg::CARE_W-1:0];
                msc_pkg::CFG_LEN:  r_len  <= i_cfg_data[msc_pkg::LEN_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // zero length acts as one, long lengths clip to the window
    always_comb begin
        if (r_len == '0) begin
            eff_len = LEN_W'(1);
        end else if ({1'b0, r_len} > LEN_W'(MAX_PATTERN)) begin
            eff_len = LEN_W'(MAX_PATTERN);
        end else begin
            eff_len = {1'b0, r_len};
        end
    end

    always_comb begin
        n_win[0] = i_item.data_byte;
        for (int k = 1; k < MAX_PATTERN; k++) begin
            n_win[k] = r_win[k-1];
        end
    end

    // window slot k holds the byte that pattern byte len-1-k lines up with
    always_comb begin
        logic [LEN_W-1:0] idx;
        logic [7:0]       pat_b;
        logic             care_b;
        window_ok = 1'b1;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            idx    = eff_len - LEN_W'(k) - LEN_W'(1);
            pat_b  = 8'h00;
            care_b = 1'b0;
            if (LEN_W'(k) < eff_len && idx < LEN_W'(msc_pkg::PAT_BYTES)) begin
                pat_b  = r_pat[{idx[4:0], 3'b000} +: 8];
                care_b = r_care[idx[4:0]];
            end
            if (care_b && (n_win[k] != pat_b)) begin
                window_ok = 1'b0;
            end
        end
    end

    assign seen_inc = (r_seen == SEEN_W'(MAX_BUFFER)) ? r_seen : r_seen + 1'b1;
    assign enough   = (seen_inc >= SEEN_W'(eff_len));
    assign found    = !r_latched && enough && window_ok;
    assign diff     = DIFF_W'(seen_inc) - DIFF_W'(eff_len);

    always_comb begin
        o_emit                = found || (i_item.last_byte && !r_latched);
        o_result.match_found  = found;
        o_result.match_offset = found ? diff[msc_pkg::OFFSET_W-1:0] : '0;
        o_result.buffer_done  = i_item.last_byte;
    end

    always_comb begin
        n_seen    = r_seen;
        n_latched = r_latched;
        if (i_accept) begin
            if (i_item.last_byte) begin
                n_seen    = '0;
                n_latched = 1'b0;
            end else begin
                n_seen    = seen_inc;
                n_latched = r_latched || found;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen    <= '0;
            r_latched <= 1'b0;
        end else begin
            r_seen    <= n_seen;
            r_latched <= n_latched;
        end
    end

    // window slots past the byte count are never compared, so no clear
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_win <= n_win;
        end
    end

endmodule

>>> design/msc_back.sv
`timescale 1ns / 1ps

module msc_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  msc_pkg::t_fifo_stat    i_q_stat,
    input  msc_pkg::t_out_item     i_q_data,
    output logic                   o_q_rd,
    input  logic                   pop,
    output logic                   empty,
    output msc_pkg::t_out_item     o_item
);

    logic               r_vld, n_vld;
    msc_pkg::t_out_item r_item;
    logic               load;

    // refill the output register when it is free or being taken
    assign load   = !i_q_stat.empty && (!r_vld || pop);
    assign o_q_rd = load;

    always_comb begin
        n_vld = r_vld;
        if (load) begin
            n_vld = 1'b1;
        end else if (pop) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_q_data;
        end
    end

    assign empty  = !r_vld;
    assign o_item = r_item;

endmodule

>>> dv/tb_masked_byte_pattern_scanner.sv
`timescale 1ns / 1ps

module tb_masked_byte_pattern_scanner;

    localparam int      IDLE_PCT     = 36;
    localparam int      RESET_CYCLES = 9;
    localparam int      DRAIN_CYCLES = 8;
    localparam int      SCAN_ITEMS   = 1950;
    localparam int      SCAN_PHASES  = 10;
    localparam int      QUIET_PHASE  = 4;
    localparam int      MAX_PRINTS   = 50;
    localparam longint  LIMIT_NS     = 64'd20_000_000;

    // register indexes past the end of the list, writes there must be dropped
    localparam logic [msc_pkg::CFG_IDX_W-1:0] CFG_SPARE6 = 3'd6;
    localparam logic [msc_pkg::CFG_IDX_W-1:0] CFG_SPARE7 = 3'd7;

    typedef enum logic [1:0] {ROW_REG, ROW_SCAN, ROW_SILENT, ROW_REPORT} t_row_kind;

    typedef struct packed {
        t_row_kind                     kind;
        logic [msc_pkg::CFG_IDX_W-1:0] idx;
        logic [msc_pkg::CFG_W-1:0]     value;
        msc_pkg::t_in_item             item;
        logic [15:0]                   reps;
        msc_pkg::t_out_item            rep;
    } t_row;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [msc_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [msc_pkg::CFG_W-1:0]     i_cfg_data;
    logic                          push;
    logic                          full;
    msc_pkg::t_in_item             i_item;
    logic                          pop;
    logic                          empty;
    msc_pkg::t_out_item            o_item;

    masked_byte_pattern_scanner dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .pop        (pop),
        .empty      (empty),
        .o_item     (o_item)
    );

    // scanner model state
    logic [msc_pkg::PAT_W-1:0]     pattern_bits = '0;
    logic [msc_pkg::CARE_W-1:0]    care_bits    = '0;
    logic [msc_pkg::LEN_REG_W-1:0] length_reg   = 6'd1;
    logic [7:0]                    win [msc_pkg::PAT_BYTES];
    int unsigned                   seen;
    bit                            latched;

    msc_pkg::t_out_item pending_reports[$];
    t_row               plan[$];
    int                 mismatches;
    int                 phase_items;
    bit                 calm;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_NS);
        $display("FAIL masked_byte_pattern_scanner");
        $finish;
    end

    function automatic int eff_len();
        if (length_reg == 0)
            return 1;
        if (length_reg > msc_pkg::PAT_BYTES)
            return msc_pkg::PAT_BYTES;
        return int'(length_reg);
    endfunction

    function automatic logic [7:0] pat_byte(int i);
        return pattern_bits[i*8 +: 8];
    endfunction

    function automatic void scan_clear();
        foreach (win[k])
            win[k] = 8'h00;
        seen    = 0;
        latched = 1'b0;
    endfunction

    function automatic void apply_reg(logic [msc_pkg::CFG_IDX_W-1:0] idx,
                                      logic [msc_pkg::CFG_W-1:0] v);
        case (idx)
            msc_pkg::CFG_PAT0, msc_pkg::CFG_PAT1,
            msc_pkg::CFG_PAT2, msc_pkg::CFG_PAT3:
                pattern_bits[int'(idx)*msc_pkg::CFG_W +: msc_pkg::CFG_W] = v;
            msc_pkg::CFG_CARE: care_bits = v[msc_pkg::CARE_W-1:0];
            msc_pkg::CFG_LEN:  length_reg = v[msc_pkg::LEN_REG_W-1:0];
            default: ;
        endcase
    endfunction

    // advance the window by one byte and work out the report it causes, if any
    function automatic bit scan_step(input logic [7:0] b, input bit is_last,
                                     output msc_pkg::t_out_item rep);
        int          len;
        bit          ok;
        bit          got;
        logic [31:0] diff;
        len = eff_len();
        got = 1'b0;
        rep = '0;
        for (int k = msc_pkg::PAT_BYTES - 1; k > 0; k--)
            win[k] = win[k-1];
        win[0] = b;
        if (seen < msc_pkg::MAX_BUFFER_DEF)
            seen++;
        if (!latched && seen >= len) begin
            ok = 1'b1;
            for (int i = 0; i < len; i++)
                if (care_bits[i] && win[len-1-i] != pat_byte(i))
                    ok = 1'b0;
            if (ok) begin
                latched          = 1'b1;
                diff             = seen - len;
                rep.match_found  = 1'b1;
                rep.match_offset = diff[msc_pkg::OFFSET_W-1:0];
                rep.buffer_done  = is_last;
                got              = 1'b1;
            end
        end
        if (is_last) begin
            if (!got && !latched) begin
                rep.match_found  = 1'b0;
                rep.match_offset = '0;
                rep.buffer_done  = 1'b1;
                got              = 1'b1;
            end
            scan_clear();
        end
        return got;
    endfunction

    function automatic t_row wr(logic [msc_pkg::CFG_IDX_W-1:0] idx,
                                logic [msc_pkg::CFG_W-1:0] v);
        t_row r;
        r       = '0;
        r.kind  = ROW_REG;
        r.idx   = idx;
        r.value = v;
        return r;
    endfunction

    function automatic t_row feed(t_row_kind k, logic [7:0] d, bit l, int n);
        t_row r;
        r                = '0;
        r.kind           = k;
        r.item.data_byte = d;
        r.item.last_byte = l;
        r.reps           = 16'(n);
        return r;
    endfunction

    function automatic t_row hit(logic [7:0] d, bit l, bit found,
                                 logic [msc_pkg::OFFSET_W-1:0] off, bit done);
        t_row r;
        r                  = feed(ROW_REPORT, d, l, 1);
        r.rep.match_found  = found;
        r.rep.match_offset = off;
        r.rep.buffer_done  = done;
        return r;
    endfunction

    task automatic flag_mismatch(string what);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task automatic check_report(msc_pkg::t_out_item got);
        msc_pkg::t_out_item want;
        if (pending_reports.size() == 0) begin
            flag_mismatch($sformatf("report with none waiting: found=%0b offset=%0d done=%0b",
                                    got.match_found, got.match_offset, got.buffer_done));
            return;
        end
        want = pending_reports.pop_front();
        if (got.match_found !== want.match_found)
            flag_mismatch($sformatf("match_found %0b, want %0b",
                                    got.match_found, want.match_found));
        if (got.match_offset !== want.match_offset)
            flag_mismatch($sformatf("match_offset %0d, want %0d",
                                    got.match_offset, want.match_offset));
        if (got.buffer_done !== want.buffer_done)
            flag_mismatch($sformatf("buffer_done %0b, want %0b",
                                    got.buffer_done, want.buffer_done));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty)
            check_report(o_item);
    end

    initial begin
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            pop <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // called at a falling edge, returns at the falling edge after the item is taken
    task automatic push_byte(input logic [7:0] d, input bit is_last, input bit keep);
        msc_pkg::t_in_item  it;
        msc_pkg::t_out_item rep;
        bit                 got;
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        it.data_byte = d;
        it.last_byte = is_last;
        push   <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        got = scan_step(d, is_last, rep);
        if (got && keep)
            pending_reports.push_back(rep);
        @(negedge i_clk);
    endtask

    task automatic settle();
        push <= 1'b0;
        @(negedge i_clk);
        while (pending_reports.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_reg(input logic [msc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [msc_pkg::CFG_W-1:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        apply_reg(idx, v);
        @(negedge i_clk);
    endtask

    task automatic load_random_setup(input int ph);
        logic [msc_pkg::CFG_W-1:0] vals [6];
        logic [31:0]               a;
        logic [31:0]               b;
        int                        first;
        int                        r;
        for (int w = 0; w < 4; w++) begin
            r = $urandom_range(7);
            vals[w] = (r == 0) ? '0 : (r == 1) ? '1 : {$urandom, $urandom};
        end
        a = $urandom;
        b = $urandom;
        case ($urandom_range(3))
            0: vals[msc_pkg::CFG_CARE] = 64'hFFFF_FFFF;
            1: vals[msc_pkg::CFG_CARE] = 64'(a);
            2: vals[msc_pkg::CFG_CARE] = 64'(a & b);
            default: vals[msc_pkg::CFG_CARE] = 64'(a | b);
        endcase
        r = $urandom_range(19);
        vals[msc_pkg::CFG_LEN] = (r == 0) ? 64'd0 : (r == 1) ? 64'($urandom_range(63, 33)) :
                                 (r == 2) ? 64'd32 : 64'($urandom_range(32, 1));
        case (ph)
            0: begin
                vals[msc_pkg::CFG_CARE] = 64'hFFFF_FFFF;
                vals[msc_pkg::CFG_LEN]  = 64'd1;
            end
            1: begin
                vals[msc_pkg::CFG_CARE] = 64'hFFFF_FFFF;
                vals[msc_pkg::CFG_LEN]  = 64'd32;
            end
            2: begin
                vals[msc_pkg::CFG_CARE] = 64'd0;
                vals[msc_pkg::CFG_LEN]  = 64'd0;
            end
            3: vals[msc_pkg::CFG_LEN] = 64'd63;
            default: ;
        endcase
        if ($urandom_range(3) == 0)
            set_reg($urandom_range(1) ? CFG_SPARE6 : CFG_SPARE7, {$urandom, $urandom});
        first = $urandom_range(5);
        for (int j = 0; j < 6; j++)
            set_reg(msc_pkg::CFG_IDX_W'((first + j) % 6), vals[(first + j) % 6]);
        i_cfg_we <= 1'b0;
    endtask

    // one buffer: random filler with the pattern planted, planted with a flaw, or absent
    task automatic scan_buffer();
        logic [7:0] body[$];
        int         n;
        int         eff;
        int         pos;
        int         mode;
        int         k;
        int         plants;
        eff = eff_len();
        if ($urandom_range(9) == 0)
            n = $urandom_range(120, eff + 12);
        else
            n = $urandom_range(eff + 12, 1);
        for (int i = 0; i < n; i++)
            body.push_back($urandom_range(1) ? 8'($urandom_range(255))
                                             : pat_byte($urandom_range(eff - 1)));
        mode = $urandom_range(9);
        if (n >= eff && mode < 8) begin
            plants = (mode < 6) ? $urandom_range(2, 1) : 1;
            for (int j = 0; j < plants; j++) begin
                pos = $urandom_range(n - eff);
                for (int i = 0; i < eff; i++)
                    if (care_bits[i])
                        body[pos+i] = pat_byte(i);
                if (mode >= 6) begin
                    k = $urandom_range(eff - 1);
                    body[pos+k] = body[pos+k] ^ 8'($urandom_range(255, 1));
                end
            end
        end
        for (int i = 0; i < n; i++)
            push_byte(body[i], i == n - 1, 1'b1);
        phase_items += n;
    endtask

    initial begin
        bit cfg_open;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        push       = 1'b0;
        i_item     = '0;
        calm       = 1'b0;
        mismatches = 0;
        cfg_open   = 1'b0;
        scan_clear();

        // reset values: length 1, no care bits, so every first byte matches
        plan.push_back(hit(8'hFF, 1'b0, 1'b1, 20'd0, 1'b0));
        plan.push_back(feed(ROW_SILENT, 8'h00, 1'b1, 1));
        plan.push_back(hit(8'h5A, 1'b1, 1'b1, 20'd0, 1'b1));
        plan.push_back(wr(msc_pkg::CFG_PAT0, 64'hFFFF_FFFF_FFFF_BEEF));
        plan.push_back(wr(msc_pkg::CFG_CARE, 64'h3));
        plan.push_back(wr(msc_pkg::CFG_LEN, 64'd2));
        plan.push_back(feed(ROW_SILENT, 8'hEF, 1'b0, 1));
        plan.push_back(feed(ROW_SILENT, 8'h00, 1'b0, 1));
        plan.push_back(feed(ROW_SILENT, 8'hEF, 1'b0, 1));
        plan.push_back(hit(8'hBE, 1'b0, 1'b1, 20'd2, 1'b0));
        // later matches in the same buffer stay quiet
        plan.push_back(feed(ROW_SILENT, 8'hEF, 1'b0, 1));
        plan.push_back(feed(ROW_SILENT, 8'hBE, 1'b1, 1));
        plan.push_back(feed(ROW_SILENT, 8'h11, 1'b0, 1));
        plan.push_back(hit(8'h22, 1'b1, 1'b0, 20'd0, 1'b1));
        // zero length behaves as one
        plan.push_back(wr(msc_pkg::CFG_LEN, 64'd0));
        plan.push_back(wr(msc_pkg::CFG_CARE, 64'h1));
        plan.push_back(feed(ROW_SILENT, 8'h00, 1'b0, 1));
        plan.push_back(hit(8'hEF, 1'b0, 1'b1, 20'd1, 1'b0));
        plan.push_back(feed(ROW_SILENT, 8'h00, 1'b1, 1));
        // oversized length clamps to 32; spare index writes must not land anywhere
        plan.push_back(wr(msc_pkg::CFG_PAT0, '1));
        plan.push_back(wr(msc_pkg::CFG_PAT1, '1));
        plan.push_back(wr(msc_pkg::CFG_PAT2, '1));
        plan.push_back(wr(msc_pkg::CFG_PAT3, '1));
        plan.push_back(wr(CFG_SPARE6, '0));
        plan.push_back(wr(CFG_SPARE7, '0));
        plan.push_back(wr(msc_pkg::CFG_CARE, 64'h8000_0001));
        plan.push_back(wr(msc_pkg::CFG_LEN, 64'd63));
        plan.push_back(feed(ROW_SCAN, 8'hFF, 1'b0, 31));
        plan.push_back(hit(8'hFF, 1'b1, 1'b1, 20'd0, 1'b1));

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[r]) begin
            if (plan[r].kind == ROW_REG) begin
                if (!cfg_open) begin
                    settle();
                    cfg_open = 1'b1;
                end
                set_reg(plan[r].idx, plan[r].value);
            end else begin
                i_cfg_we <= 1'b0;
                cfg_open = 1'b0;
                for (int n = 0; n < plan[r].reps; n++)
                    push_byte(plan[r].item.data_byte, plan[r].item.last_byte,
                              plan[r].kind == ROW_SCAN);
                if (plan[r].kind == ROW_REPORT)
                    pending_reports.push_back(plan[r].rep);
            end
        end

        for (int ph = 0; ph < SCAN_PHASES; ph++) begin
            settle();
            calm = (ph == QUIET_PHASE);
            load_random_setup(ph);
            phase_items = 0;
            while (phase_items < SCAN_ITEMS / SCAN_PHASES)
                scan_buffer();
        end
        calm = 1'b0;

        settle();
        if (mismatches == 0)
            $display("PASS masked_byte_pattern_scanner");
        else
            $display("FAIL masked_byte_pattern_scanner");
        $finish;
    end

endmodule
